### hw/rtl/assert_macros.svh
// Assertion macros used by the line capture back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/sltc_pkg.sv
// Types and constants shared by the serial text line capture block.
package sltc_pkg;

    localparam int RING_LINES = 64;
    localparam int LINE_CAP   = 128;

    // one extra slot holds the line being built
    localparam int SLOTS     = RING_LINES + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int COL_W     = $clog2(LINE_CAP);
    localparam int LEN_W     = COL_W;
    localparam int CNT_W     = $clog2(RING_LINES + 1);
    localparam int MEM_DEPTH = SLOTS * LINE_CAP;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [1:0] CMD_FEED  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        K_CHAR,
        K_CR,
        K_LF,
        K_BS,
        K_TAB,
        K_CTRL,
        K_READ,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [6:0]  back;
        logic [6:0]  col;
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAB,
        S_RDATA
    } t_state;

endpackage

### hw/rtl/serial_text_line_capture.sv
// Serial text line capture: top level joining front end, queue and back end.
//
// Input channel (i_valid / o_stall) carries one command per transfer: feed a
// console byte, read a character, or clear all lines. Output channel
// (o_valid / i_stall) carries one result per read: character, valid flag and
// line length. Feed and clear give no result.
// A read result passes through the input register, a queue entry, the line
// store read register and the result register. While idle, the back end takes
// one operation per cycle for plain bytes, line ends, backspace and clear; a
// read holds it for a memory read, then the result register load, which waits
// out a receiver stall; a tab holds it to take the tab, write each space
// through the single line store write port, and finish.
// Lines are built in place in a ring slot, so a line end copies nothing.
// A two-entry queue separates the front end from the back end, so input keeps
// flowing while a result waits. When the receiver stalls, the result register
// holds and the back end waits on the next read; feed work goes on until the
// queue and the input register fill, then o_stall rises.
// Reset empties the ring and the current line at once; the line store needs no
// clearing pass, since a read reports only characters below the line length.
module serial_text_line_capture
    import sltc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_lines_back,
    input  logic [6:0] i_column,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic [6:0] o_line_length
);

    logic push, q_full, q_valid, q_pop;
    t_op  f_op, q_op;

    sltc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_lines_back (i_lines_back),
        .i_column     (i_column),
        .o_push       (push),
        .o_op         (f_op),
        .i_q_full     (q_full)
    );

    sltc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    sltc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_out    (o_char_out),
        .o_char_valid  (o_char_valid),
        .o_line_length (o_line_length)
    );

endmodule

### hw/rtl/sltc_front.sv
// Front end: accepts input transfers and classifies them into operations.
module sltc_front
    import sltc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_lines_back,
    input  logic [6:0] i_column,
    output logic       o_push,
    output t_op        o_op,
    input  logic       i_q_full
);

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    logic  r_valid, n_valid;
    t_op   r_op, n_op;
    logic  accept;
    logic  keep;
    t_kind kind;

    always_comb begin
        kind = K_CTRL;
        keep = 1'b1;
        case (i_cmd)
            CMD_FEED: begin
                if (i_data_byte == CH_CR) begin
                    kind = K_CR;
                end else if (i_data_byte == CH_LF) begin
                    kind = K_LF;
                end else if (i_data_byte == CH_BS || i_data_byte == CH_DEL) begin
                    kind = K_BS;
                end else if (i_data_byte == CH_TAB) begin
                    kind = K_TAB;
                end else if (i_data_byte < CH_SP) begin
                    kind = K_CTRL;
                end else begin
                    kind = K_CHAR;
                end
            end
            CMD_READ:  kind = K_READ;
            CMD_CLEAR: kind = K_CLEAR;
            default:   keep = 1'b0;
        endcase
    end

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_op    = r_op;

    always_comb begin
        n_valid = r_valid && !o_push;
        n_op    = r_op;
        if (accept && keep) begin
            n_valid = 1'b1;
            n_op    = '{kind: kind, data: i_data_byte, back: i_lines_back, col: i_column};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

endmodule

### hw/rtl/sltc_queue.sv
// Two-entry operation queue between front and back ends.
module sltc_queue
    import sltc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    t_op        r_ent [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_ent[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = do_push ? ~r_wptr : r_wptr;
        n_rptr = do_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wptr] <= i_op;
        end
    end

endmodule

### hw/rtl/sltc_back.sv
// Back end: line store, ring bookkeeping, tab sequencer and read result register.
`include "assert_macros.svh"

module sltc_back
    import sltc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_op        i_q_op,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic [6:0] o_line_length
);

    localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;
    localparam int EX_W  = (CNT_W > 7) ? CNT_W : 7;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(int'(slot) * LINE_CAP + int'(col));
    endfunction

    logic [7:0]       r_mem [MEM_DEPTH];
    logic [LEN_W-1:0] r_len_mem [SLOTS];

    t_state           r_state, n_state;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_cur_len, n_cur_len;
    logic             r_after_cr, n_after_cr;
    logic [3:0]       r_pad, n_pad;
    logic             r_rd_cur, n_rd_cur;
    logic             r_rd_exist, n_rd_exist;
    logic [6:0]       r_rd_col, n_rd_col;
    logic [7:0]       r_rd_data;
    logic [LEN_W-1:0] r_len_rd;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_char, n_char;
    logic             r_cv, n_cv;
    logic [6:0]       r_ll, n_ll;

    logic              wr_en, lw_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data;
    logic [SLOT_W-1:0] head_inc, back_s, pos;
    logic              room, exists, load;
    logic [LEN_W-1:0]  len_eff;

    assign head_inc = (r_head == SLOT_W'(SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign room     = (int'(r_cur_len) + 1) < LINE_CAP;
    assign back_s   = SLOT_W'(i_q_op.back);
    assign pos      = (r_head >= back_s) ? r_head - back_s
                                         : r_head + SLOT_W'(SLOTS) - back_s;
    assign exists   = (i_q_op.back == 7'd0) || (EX_W'(i_q_op.back) <= EX_W'(r_count));
    assign len_eff  = !r_rd_exist ? '0 : (r_rd_cur ? r_cur_len : r_len_rd);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_cur_len   = r_cur_len;
        n_after_cr  = r_after_cr;
        n_pad       = r_pad;
        n_rd_cur    = r_rd_cur;
        n_rd_exist  = r_rd_exist;
        n_rd_col    = r_rd_col;
        n_char      = r_char;
        n_cv        = r_cv;
        n_ll        = r_ll;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = mem_addr(r_head, r_cur_len);
        wr_data     = i_q_op.data;
        lw_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = mem_addr((i_q_op.back == 7'd0) ? r_head : pos, COL_W'(i_q_op.col));
        load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_op.kind)
                        K_CHAR: begin
                            n_after_cr = 1'b0;
                            if (room) begin
                                wr_en     = 1'b1;
                                n_cur_len = r_cur_len + 1'b1;
                            end
                        end
                        K_CR, K_LF: begin
                            if (i_q_op.kind == K_LF && r_after_cr) begin
                                n_after_cr = 1'b0;
                            end else begin
                                lw_en     = 1'b1;
                                n_head    = head_inc;
                                n_cur_len = '0;
                                n_after_cr = (i_q_op.kind == K_CR);
                                if (r_count != CNT_W'(RING_LINES)) begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                        K_BS: begin
                            n_after_cr = 1'b0;
                            if (r_cur_len != '0) begin
                                n_cur_len = r_cur_len - 1'b1;
                            end
                        end
                        K_TAB: begin
                            n_after_cr = 1'b0;
                            n_pad      = 4'd8 - {1'b0, r_cur_len[2:0]};
                            n_state    = S_TAB;
                        end
                        K_READ: begin
                            rd_en      = 1'b1;
                            n_rd_cur   = (i_q_op.back == 7'd0);
                            n_rd_exist = exists;
                            n_rd_col   = i_q_op.col;
                            n_state    = S_RDATA;
                        end
                        K_CLEAR: begin
                            n_head     = '0;
                            n_count    = '0;
                            n_cur_len  = '0;
                            n_after_cr = 1'b0;
                        end
                        default: begin
                            n_after_cr = 1'b0;
                        end
                    endcase
                end
            end
            S_TAB: begin
                if (r_pad != 4'd0 && room) begin
                    wr_en     = 1'b1;
                    wr_data   = 8'h20;
                    n_cur_len = r_cur_len + 1'b1;
                    n_pad     = r_pad - 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RDATA: begin
                if (!r_out_valid || !i_stall) begin
                    load    = 1'b1;
                    n_cv    = CMP_W'(r_rd_col) < CMP_W'(len_eff);
                    n_char  = n_cv ? r_rd_data : 8'h00;
                    n_ll    = 7'(len_eff);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_cur_len   <= '0;
            r_after_cr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_cur_len   <= n_cur_len;
            r_after_cr  <= n_after_cr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad      <= n_pad;
        r_rd_cur   <= n_rd_cur;
        r_rd_exist <= n_rd_exist;
        r_rd_col   <= n_rd_col;
        r_char     <= n_char;
        r_cv       <= n_cv;
        r_ll       <= n_ll;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            r_len_mem[r_head] <= r_cur_len;
        end
        if (rd_en) begin
            r_len_rd <= r_len_mem[pos];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_char_out    = r_char;
    assign o_char_valid  = r_cv;
    assign o_line_length = r_ll;

    `ASSERT_ALWAYS(a_len_cap, i_clk, i_rst_n, int'(r_cur_len) < LINE_CAP, "line over cap")
    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, int'(r_count) <= RING_LINES, "ring count over")
    `ASSERT_ALWAYS(a_head_range, i_clk, i_rst_n, int'(r_head) < SLOTS, "head out of range")
    `ASSERT_NEXT(a_result_load, i_clk, i_rst_n, r_state == S_RDATA && !(r_out_valid && i_stall), o_valid && r_state == S_IDLE, "read result not loaded")
    `ASSERT_NEXT(a_tab_pad, i_clk, i_rst_n, r_state == S_IDLE && i_q_valid && i_q_op.kind == K_TAB, r_state == S_TAB && r_pad != 4'd0 && r_pad <= 4'd8, "bad tab pad")

endmodule
